>>> hdl/drrip_pkg.sv
// ----------------------------------------------------------------------------
// drrip_pkg
// shared types, field widths and defaults for the drrip replacement block
// ----------------------------------------------------------------------------
package drrip_pkg;

  // default geometry
  localparam int unsigned DefNumSets    = 2048;
  localparam int unsigned DefNumWays    = 16;
  localparam int unsigned DefLeaderCnt  = 64;
  localparam int unsigned DefCounterW   = 10;

  // beat field widths
  localparam int unsigned SetIdxW   = 11;
  localparam int unsigned WayIdxW   = 4;
  localparam int unsigned DrawW     = 5;
  localparam int unsigned VictimW   = 4;
  localparam int unsigned SelectorW = 10;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 16;

  typedef logic [1:0] rrpv_t;

  localparam rrpv_t RrpvMax  = 2'd3;
  localparam rrpv_t RrpvLong = 2'd2;
  localparam rrpv_t RrpvNear = 2'd0;

  typedef enum logic {
    CMD_SELECT = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    LEAD_NONE  = 2'd0,
    LEAD_SRRIP = 2'd1,
    LEAD_BRRIP = 2'd2
  } lead_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRAP,
    S_READ,
    S_SCAN,
    S_EMIT
  } state_e;

endpackage

>>> hdl/drrip_cache_replacement.sv
// ----------------------------------------------------------------------------
// drrip_cache_replacement
// set-dueling rrip victim selection and line update over a per-set row memory
// ----------------------------------------------------------------------------
// steps: from input beat to result beat, range check, read, level passes of
//   the shared compare unit with write-back, result load; a modulo reduction
//   step comes in for each subtract when NUM_SETS or NUM_WAYS is below the
//   field range
// input: a new beat is held off until the result register of the last one is
//   loaded; this is set by the single read-modify-write port of the row memory
//   and the level search loop
// reset: counter to midpoint, then a clearing pass over all NUM_SETS rows writes
//   every row to all lines at 3 with its leader mark; no input beat meanwhile
module drrip_cache_replacement import drrip_pkg::*; #(
  parameter int unsigned NUM_SETS     = DefNumSets,
  parameter int unsigned NUM_WAYS     = DefNumWays,
  parameter int unsigned LEADER_COUNT = DefLeaderCnt,
  parameter int unsigned COUNTER_BITS = DefCounterW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // set_index[10:0], way_index[14:11], hit[15], random_draw[20:16], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // command[0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // victim_way[3:0], selector_value[13:4], zero pad
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned SetW   = $clog2(NUM_SETS);
  localparam int unsigned WayW   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned SrW    = (SetW > SetIdxW) ? SetW : SetIdxW;
  localparam int unsigned WrW    = (WayW > WayIdxW) ? WayW : WayIdxW;
  localparam int unsigned RowW   = 2 * NUM_WAYS + 2;
  localparam int unsigned LcW    = $clog2(LEADER_COUNT + 1);
  localparam int unsigned RemW   = $clog2(LEADER_COUNT) + 1;
  localparam int unsigned LeadStep = NUM_SETS / LEADER_COUNT;
  localparam int unsigned LeadRem  = NUM_SETS % LEADER_COUNT;
  localparam logic [COUNTER_BITS-1:0] CtrMax = '1;
  localparam logic [COUNTER_BITS-1:0] CtrMid = COUNTER_BITS'(2 ** (COUNTER_BITS - 1));
  localparam logic [COUNTER_BITS-1:0] CtrThr =
    COUNTER_BITS'((2 ** COUNTER_BITS - 1) / 2);

  typedef logic [NUM_WAYS-1:0][1:0] row_rrpv_t;

  state_e                state_q, state_d;
  logic [SetW-1:0]       clr_addr_q, clr_addr_d;
  logic [SetW:0]         lead_pos_q, lead_pos_d;
  logic [RemW-1:0]       lead_rem_q, lead_rem_d;
  logic [LcW-1:0]        lead_cnt_q, lead_cnt_d;
  logic [COUNTER_BITS-1:0] ctr_q, ctr_d;
  logic                  out_valid_q, out_valid_d;
  logic [OutDataW-1:0]   out_data_q, out_data_d;

  cmd_e                  cmd_q, cmd_d;
  logic [SrW-1:0]        set_q, set_d;
  logic [WrW-1:0]        way_q, way_d;
  logic                  hit_q, hit_d;
  logic [DrawW-1:0]      draw_q, draw_d;
  rrpv_t                 level_q, level_d;
  logic [WayW-1:0]       victim_q, victim_d;

  logic [RowW-1:0]       mem_q [NUM_SETS];
  logic [RowW-1:0]       rd_row_q;
  logic                  mem_re, mem_we;
  logic [SetW-1:0]       mem_waddr;
  logic [RowW-1:0]       mem_wdata;
  logic [SetW-1:0]       set_addr;

  row_rrpv_t             rrpv_rd, aged_row, upd_row;
  lead_e                 kind_rd, clr_kind;
  logic [NUM_WAYS-1:0]   lvl_hit;
  logic [WayW-1:0]       lvl_first;
  rrpv_t                 age_add, bimodal, ins_val;
  logic [RemW-1:0]       rem_sum;
  logic                  clr_is_lead;
  logic                  set_over, way_over;
  logic [COUNTER_BITS-1:0] ctr_next;

  assign set_addr = set_q[SetW-1:0];
  assign rrpv_rd  = rd_row_q[2*NUM_WAYS-1:0];
  assign kind_rd  = lead_e'(rd_row_q[RowW-1 -: 2]);

  assign set_over = ({1'b0, set_q} >= (SrW + 1)'(NUM_SETS));
  assign way_over = ({1'b0, way_q} >= (WrW + 1)'(NUM_WAYS));

  // leader positions floor(i * sets / leaders) stepped without a divider
  assign rem_sum     = lead_rem_q + RemW'(LeadRem);
  assign clr_is_lead = ({1'b0, clr_addr_q} == lead_pos_q) &&
                       (lead_cnt_q != LcW'(LEADER_COUNT));
  assign clr_kind    = !clr_is_lead ? LEAD_NONE :
                       (lead_cnt_q[0] ? LEAD_BRRIP : LEAD_SRRIP);

  // shared level compare: ways holding the level under test
  always_comb begin
    lvl_first = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      lvl_hit[w] = (rrpv_rd[w] == level_q);
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (lvl_hit[w]) begin
        lvl_first = WayW'(w);
      end
    end
  end

  // aging by the distance from the found level to the top value
  assign age_add = RrpvMax - level_q;
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged_row[w] = rrpv_rd[w] + age_add;
    end
  end

  // insertion value and counter feedback for the update command
  always_comb begin
    bimodal  = (draw_q == '0) ? RrpvLong : RrpvMax;
    ctr_next = ctr_q;
    if (hit_q) begin
      ins_val = RrpvNear;
    end else begin
      case (kind_rd)
        LEAD_SRRIP: begin
          ins_val = RrpvLong;
          if (ctr_q != CtrMax) ctr_next = ctr_q + 1'b1;
        end
        LEAD_BRRIP: begin
          ins_val = bimodal;
          if (ctr_q != '0) ctr_next = ctr_q - 1'b1;
        end
        default: begin
          ins_val = (ctr_q >= CtrThr) ? bimodal : RrpvLong;
        end
      endcase
    end
    upd_row = rrpv_rd;
    upd_row[way_q[WayW-1:0]] = ins_val;
  end

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    lead_pos_d  = lead_pos_q;
    lead_rem_d  = lead_rem_q;
    lead_cnt_d  = lead_cnt_q;
    ctr_d       = ctr_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    cmd_d       = cmd_q;
    set_d       = set_q;
    way_d       = way_q;
    hit_d       = hit_q;
    draw_d      = draw_q;
    level_d     = level_q;
    victim_d    = victim_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = set_addr;
    mem_wdata   = rd_row_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = {clr_kind, {NUM_WAYS{RrpvMax}}};
        if (clr_is_lead) begin
          lead_cnt_d = lead_cnt_q + 1'b1;
          if (rem_sum >= RemW'(LEADER_COUNT)) begin
            lead_rem_d = rem_sum - RemW'(LEADER_COUNT);
            lead_pos_d = lead_pos_q + (SetW + 1)'(LeadStep + 1);
          end else begin
            lead_rem_d = rem_sum;
            lead_pos_d = lead_pos_q + (SetW + 1)'(LeadStep);
          end
        end
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == SetW'(NUM_SETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d   = cmd_e'(s_axis_tuser);
          set_d   = SrW'(s_axis_tdata[10:0]);
          way_d   = WrW'(s_axis_tdata[14:11]);
          hit_d   = s_axis_tdata[15];
          draw_d  = s_axis_tdata[20:16];
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        // one subtract a cycle until both indices are in range
        if (set_over) begin
          set_d = SrW'({1'b0, set_q} - (SrW + 1)'(NUM_SETS));
        end else if (way_over) begin
          way_d = WrW'({1'b0, way_q} - (WrW + 1)'(NUM_WAYS));
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        mem_re  = 1'b1;
        level_d = RrpvMax;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (cmd_q == CMD_SELECT) begin
          if (|lvl_hit) begin
            mem_we    = 1'b1;
            mem_wdata = {rd_row_q[RowW-1 -: 2], aged_row};
            victim_d  = lvl_first;
            state_d   = S_EMIT;
          end else begin
            level_d = level_q - 1'b1;
          end
        end else begin
          mem_we    = 1'b1;
          mem_wdata = {rd_row_q[RowW-1 -: 2], upd_row};
          ctr_d     = ctr_next;
          victim_d  = '0;
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = OutDataW'({SelectorW'(ctr_q), VictimW'(victim_q)});
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_addr_q  <= '0;
      lead_pos_q  <= '0;
      lead_rem_q  <= '0;
      lead_cnt_q  <= '0;
      ctr_q       <= CtrMid;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      lead_pos_q  <= lead_pos_d;
      lead_rem_q  <= lead_rem_d;
      lead_cnt_q  <= lead_cnt_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    cmd_q      <= cmd_d;
    set_q      <= set_d;
    way_q      <= way_d;
    hit_q      <= hit_d;
    draw_q     <= draw_d;
    level_q    <= level_d;
    victim_q   <= victim_d;
  end

  // row memory: one row per set, leader mark in the top two bits
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_row_q <= mem_q[set_addr];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // the bottom level always matches, so the search never runs past it
  a_level_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && cmd_q == CMD_SELECT && level_q == RrpvNear) |-> (|lvl_hit))
    else $error("level search found no way at the bottom level");

  // the selection counter moves by at most one step per beat
  a_ctr_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(ctr_q) |->
      (ctr_q == $past(ctr_q) + 1'b1) || (ctr_q == $past(ctr_q) - 1'b1))
    else $error("selection counter jumped");

  // a new result only comes out of the emit step
  a_emit_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !out_valid_q) |-> (state_q == S_EMIT))
    else $error("result raised outside emit step");

  // no beat is taken while the clearing pass runs
  a_no_accept_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!s_axis_tready && !mem_re))
    else $error("access during clearing pass");

endmodule
